// ===== src/fdes_pkg.sv =====
// fdes_pkg: shared constants, item type and helpers for the fat directory entry scanner
// used by fdes_front, fdes_queue, fdes_back and the top level; no dependencies
package fdes_pkg;

  // byte and attribute codes of a short directory entry
  localparam logic [7:0] BYTE_END      = 8'h00;
  localparam logic [7:0] BYTE_DELETED  = 8'hE5;
  localparam logic [7:0] BYTE_SPACE    = 8'h20;
  localparam logic [7:0] BYTE_DOT      = 8'h2E;
  localparam logic [7:0] ATTR_LONGNAME = 8'h0F;
  localparam logic [7:0] ATTR_VOLUME   = 8'h08;
  localparam logic [7:0] ATTR_DIR      = 8'h10;
  localparam logic [7:0] CASE_OFFSET   = 8'd32;
  localparam logic [15:0] COUNT_MAX    = 16'hFFFF;

  // field widths
  localparam int NAME_W    = 64;
  localparam int EXT_W     = 24;
  localparam int ORD_W     = 16;
  localparam int WORD_W    = 32;
  localparam int NAME_HI_W = 32;
  localparam int LEN_W     = 4;
  localparam int NAME_CHARS = 12;

  // classified entry passed from front to back
  typedef struct packed {
    logic              is_end;
    logic [ORD_W-1:0]  ordinal;
    logic              is_selected;
    logic [NAME_W-1:0] name;
    logic [EXT_W-1:0]  ext;
    logic              is_directory;
    logic [WORD_W-1:0] start_cluster;
    logic [WORD_W-1:0] size_bytes;
  } entry_item_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // lower-case only 'A'..'Z'
  function automatic logic [7:0] lower_char(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c inside {[8'h41:8'h5A]}) begin
      r = c + CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

// ===== src/fat_directory_entry_scanner_unit.sv =====
// fat_directory_entry_scanner_unit: top level of the directory entry scanner
// depends on fdes_pkg, fdes_front, fdes_queue and fdes_back
//
//  channel  | ports                 | content
//  ---------+-----------------------+-------------------------------------------
//  input    | in_tvalid/tready/...  | fields of one directory entry per item
//  result   | out_tvalid/tready/... | one decoded entry or end marker per item
//
// one entry is accepted every cycle while the queue is not full; each entry is
// classified into the queue, then its name is built into the result register.
// the two-entry queue lets input flow while a result waits; in_tready drops
// only when the queue is full. reset clears ordinal, end state and queue.
module fat_directory_entry_scanner_unit
  import fdes_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // entry_name[63:0], entry_ext[87:64], entry_attributes[95:88],
  // cluster_high_half[111:96], cluster_low_half[127:112], entry_size[159:128],
  // wanted_ordinal[175:160]
  input  logic [175:0] in_tdata,
  // dir_start[0]
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // ordinal[15:0], is_selected[16], name_low[80:17], name_high[112:81],
  // name_length[116:113], start_cluster[148:117], is_directory[149],
  // size_bytes[181:150], zero[183:182]
  output logic [183:0] out_tdata,
  // is_end
  output logic         out_tlast
);

  logic                 accept;
  logic                 push;
  logic                 pop;
  entry_item_t          push_item;
  entry_item_t          pop_item;
  q_status_t            status;
  logic [ORD_W-1:0]     ordinal;
  logic                 is_selected;
  logic [NAME_W-1:0]    name_low;
  logic [NAME_HI_W-1:0] name_high;
  logic [LEN_W-1:0]     name_length;
  logic [WORD_W-1:0]    start_cluster;
  logic                 is_directory;
  logic [WORD_W-1:0]    size_bytes;

  assign in_tready = !status.full;
  assign accept    = in_tvalid && in_tready;

  // classification and directory state
  fdes_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .accept            (accept),
    .entry_name        (in_tdata[63:0]),
    .entry_ext         (in_tdata[87:64]),
    .entry_attributes  (in_tdata[95:88]),
    .cluster_high_half (in_tdata[111:96]),
    .cluster_low_half  (in_tdata[127:112]),
    .entry_size        (in_tdata[159:128]),
    .dir_start         (in_tuser),
    .wanted_ordinal    (in_tdata[175:160]),
    .push              (push),
    .push_item         (push_item)
  );

  // decoupling queue
  fdes_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .status    (status)
  );

  // name build and result register
  fdes_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .item              (pop_item),
    .status            (status),
    .pop               (pop),
    .out_valid         (out_tvalid),
    .out_ready         (out_tready),
    .out_is_end        (out_tlast),
    .out_ordinal       (ordinal),
    .out_is_selected   (is_selected),
    .out_name_low      (name_low),
    .out_name_high     (name_high),
    .out_name_length   (name_length),
    .out_start_cluster (start_cluster),
    .out_is_directory  (is_directory),
    .out_size_bytes    (size_bytes)
  );

  assign out_tdata = {2'b00, size_bytes, is_directory, start_cluster, name_length,
                      name_high, name_low, is_selected, ordinal};

endmodule

// ===== src/fdes_front.sv =====
// fdes_front: accepts entries, tracks ordinal and end-of-directory state, classifies
// depends on fdes_pkg; pushes visible and end items into fdes_queue
module fdes_front
  import fdes_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [NAME_W-1:0] entry_name,
  input  logic [EXT_W-1:0]  entry_ext,
  input  logic [7:0]        entry_attributes,
  input  logic [15:0]       cluster_high_half,
  input  logic [15:0]       cluster_low_half,
  input  logic [WORD_W-1:0] entry_size,
  input  logic              dir_start,
  input  logic [ORD_W-1:0]  wanted_ordinal,
  output logic              push,
  output entry_item_t       push_item
);

  logic [ORD_W-1:0] count_r, count_nxt;
  logic             ended_r, ended_nxt;
  logic [ORD_W-1:0] cnt_eff;
  logic             ended_eff;
  logic [7:0]       first_byte;
  logic             hidden;

  // classification of the incoming entry
  always_comb begin
    cnt_eff    = dir_start ? '0 : count_r;
    ended_eff  = dir_start ? 1'b0 : ended_r;
    first_byte = entry_name[7:0];
    hidden     = (first_byte == BYTE_DELETED) || (entry_attributes == ATTR_LONGNAME) ||
                 ((entry_attributes & ATTR_VOLUME) != 8'h00);

    count_nxt = count_r;
    ended_nxt = ended_r;
    push      = 1'b0;
    push_item = '0;

    if (accept) begin
      count_nxt = cnt_eff;
      ended_nxt = ended_eff;
      if (!ended_eff) begin
        if (first_byte == BYTE_END) begin
          // end marker: one end item, everything else zero
          ended_nxt        = 1'b1;
          push             = 1'b1;
          push_item.is_end = 1'b1;
        end else if (!hidden) begin
          push                    = 1'b1;
          push_item.ordinal       = cnt_eff;
          push_item.is_selected   = (cnt_eff == wanted_ordinal);
          push_item.name          = entry_name;
          push_item.ext           = entry_ext;
          push_item.is_directory  = (entry_attributes & ATTR_DIR) != 8'h00;
          push_item.start_cluster = {cluster_high_half, cluster_low_half};
          push_item.size_bytes    = entry_size;
          if (cnt_eff != COUNT_MAX) begin
            count_nxt = cnt_eff + ORD_W'(1);
          end
        end
      end
    end
  end

  // directory state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ended_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ended_r <= ended_nxt;
    end
  end

endmodule

// ===== src/fdes_queue.sv =====
// fdes_queue: two-entry queue of classified items between front and back
// depends on fdes_pkg for entry_item_t and q_status_t
module fdes_queue
  import fdes_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  entry_item_t push_item,
  input  logic        pop,
  output entry_item_t pop_item,
  output q_status_t   status
);

  entry_item_t slot_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  fill_r, fill_nxt;

  assign status.full  = (fill_r == 2'd2);
  assign status.empty = (fill_r == 2'd0);
  assign pop_item     = slot_r[rd_ptr_r];

  // pointer and fill update
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 2'd1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // item storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== src/fdes_back.sv =====
// fdes_back: builds the lower-cased 8.3 name and holds the result register
// depends on fdes_pkg; drains items from fdes_queue
module fdes_back
  import fdes_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  entry_item_t          item,
  input  q_status_t            status,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_is_end,
  output logic [ORD_W-1:0]     out_ordinal,
  output logic                 out_is_selected,
  output logic [NAME_W-1:0]    out_name_low,
  output logic [NAME_HI_W-1:0] out_name_high,
  output logic [LEN_W-1:0]     out_name_length,
  output logic [WORD_W-1:0]    out_start_cluster,
  output logic                 out_is_directory,
  output logic [WORD_W-1:0]    out_size_bytes
);

  logic                  valid_r, valid_nxt;
  logic                  is_end_r;
  logic [ORD_W-1:0]      ordinal_r;
  logic                  selected_r;
  logic [NAME_W-1:0]     name_low_r;
  logic [NAME_HI_W-1:0]  name_high_r;
  logic [LEN_W-1:0]      name_len_r;
  logic [WORD_W-1:0]     cluster_r;
  logic                  is_dir_r;
  logic [WORD_W-1:0]     size_r;

  logic [LEN_W-1:0]      base_len;
  logic [1:0]            ext_len;
  logic                  has_ext;
  logic [7:0]            base_lc [8];
  logic [7:0]            ext_lc [3];
  logic [7:0]            chars [NAME_CHARS];
  logic [LEN_W-1:0]      name_len;

  assign pop       = !status.empty && (!valid_r || out_ready);
  assign valid_nxt = pop ? 1'b1 : (out_ready ? 1'b0 : valid_r);

  // base and extension lengths, up to the first space
  always_comb begin
    base_len = LEN_W'(8);
    for (int k = 7; k >= 0; k--) begin
      if (item.name[8*k +: 8] == BYTE_SPACE) begin
        base_len = LEN_W'(k);
      end
    end
    has_ext = (item.ext[7:0] != BYTE_SPACE);
    ext_len = 2'd3;
    for (int k = 2; k >= 1; k--) begin
      if (item.ext[8*k +: 8] == BYTE_SPACE) begin
        ext_len = 2'(k);
      end
    end
    for (int k = 0; k < 8; k++) begin
      base_lc[k] = lower_char(item.name[8*k +: 8]);
    end
    for (int k = 0; k < 3; k++) begin
      ext_lc[k] = lower_char(item.ext[8*k +: 8]);
    end
  end

  // place each output character position
  always_comb begin
    for (int p = 0; p < NAME_CHARS; p++) begin
      chars[p] = 8'h00;
      for (int k = 0; k < 8; k++) begin
        if ((k == p) && (k < int'(base_len))) begin
          chars[p] = base_lc[k];
        end
      end
      if (has_ext && (p == int'(base_len))) begin
        chars[p] = BYTE_DOT;
      end
      for (int k = 0; k < 3; k++) begin
        if (has_ext && (p == int'(base_len) + 1 + k) && (k < int'(ext_len))) begin
          chars[p] = ext_lc[k];
        end
      end
    end
    name_len = has_ext ? (base_len + LEN_W'(ext_len) + LEN_W'(1)) : base_len;
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // result payload; end items carry zeros
  always_ff @(posedge clk) begin
    if (pop) begin
      is_end_r <= item.is_end;
      if (item.is_end) begin
        ordinal_r   <= '0;
        selected_r  <= 1'b0;
        name_low_r  <= '0;
        name_high_r <= '0;
        name_len_r  <= '0;
        cluster_r   <= '0;
        is_dir_r    <= 1'b0;
        size_r      <= '0;
      end else begin
        ordinal_r   <= item.ordinal;
        selected_r  <= item.is_selected;
        name_low_r  <= {chars[7], chars[6], chars[5], chars[4],
                        chars[3], chars[2], chars[1], chars[0]};
        name_high_r <= {chars[11], chars[10], chars[9], chars[8]};
        name_len_r  <= name_len;
        cluster_r   <= item.start_cluster;
        is_dir_r    <= item.is_directory;
        size_r      <= item.size_bytes;
      end
    end
  end

  assign out_valid         = valid_r;
  assign out_is_end        = is_end_r;
  assign out_ordinal       = ordinal_r;
  assign out_is_selected   = selected_r;
  assign out_name_low      = name_low_r;
  assign out_name_high     = name_high_r;
  assign out_name_length   = name_len_r;
  assign out_start_cluster = cluster_r;
  assign out_is_directory  = is_dir_r;
  assign out_size_bytes    = size_r;

endmodule

// ===== dv/fdes_scan_checker.sv =====
// fdes_scan_checker: watches the entry and result streams of the directory entry scanner,
// predicts each decoded entry or end marker and compares it with the result stream
// depends on fdes_pkg for the byte and attribute codes
module fdes_scan_checker
  import fdes_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [175:0] in_tdata,
  input  logic         in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [183:0] out_tdata,
  input  logic         out_tlast,
  output int           fail_count,
  output int           pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;

  typedef struct packed {
    logic              is_end;
    logic [ORD_W-1:0]  ordinal;
    logic              is_selected;
    logic [63:0]       name_low;
    logic [31:0]       name_high;
    logic [LEN_W-1:0]  name_length;
    logic [31:0]       start_cluster;
    logic              is_directory;
    logic [31:0]       size_bytes;
  } decoded_entry_t;

  // scanner state as seen from outside
  logic [ORD_W-1:0] entry_count = '0;
  logic             dir_closed = 1'b0;
  decoded_entry_t   decoded_q[$];
  int               errs = 0;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) return c + CASE_OFFSET;
    return c;
  endfunction

  // advance the scanner state by one entry; returns 1 when the entry gives a result
  function automatic bit decode_entry(input logic [175:0] data, input logic new_dir,
                                      output decoded_entry_t r);
    logic [63:0] name;
    logic [23:0] ext;
    logic [7:0]  attr;
    logic [95:0] chars;
    logic [7:0]  c;
    int          len;
    int          k;
    bit          stop;
    name = data[63:0];
    ext  = data[87:64];
    attr = data[95:88];
    r = '0;
    if (new_dir) begin
      entry_count = '0;
      dir_closed  = 1'b0;
    end
    if (dir_closed) return 0;
    if (name[7:0] == BYTE_END) begin
      dir_closed = 1'b1;
      r.is_end = 1'b1;
      return 1;
    end
    if (name[7:0] == BYTE_DELETED || attr == ATTR_LONGNAME || (attr & ATTR_VOLUME) != 0)
      return 0;

    // base name up to the first space, then dot and extension if present
    chars = '0;
    len = 0;
    stop = 0;
    for (k = 0; k < 8; k++) begin
      c = name[8*k +: 8];
      if (c == BYTE_SPACE) stop = 1;
      if (!stop) begin
        chars[8*len +: 8] = fold_case(c);
        len++;
      end
    end
    if (ext[7:0] != BYTE_SPACE) begin
      chars[8*len +: 8] = BYTE_DOT;
      len++;
      stop = 0;
      for (k = 0; k < 3; k++) begin
        c = ext[8*k +: 8];
        if (c == BYTE_SPACE) stop = 1;
        if (!stop) begin
          chars[8*len +: 8] = fold_case(c);
          len++;
        end
      end
    end

    r.ordinal       = entry_count;
    r.is_selected   = (entry_count == data[175:160]);
    r.name_low      = chars[63:0];
    r.name_high     = chars[95:64];
    r.name_length   = 4'(len);
    r.start_cluster = {data[111:96], data[127:112]};
    r.is_directory  = (attr & ATTR_DIR) != 0;
    r.size_bytes    = data[159:128];
    // ordinal saturates at the top
    if (entry_count != COUNT_MAX) entry_count = entry_count + ORD_W'(1);
    return 1;
  endfunction

  function automatic void check_field(input string field, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      errs++;
    end
  endfunction

  // compare results first: a result never belongs to the entry of the same edge
  always @(posedge clk) begin
    decoded_entry_t want;
    if (!rst_n) begin
      decoded_q.delete();
      entry_count = '0;
      dir_closed  = 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (decoded_q.size() == 0) begin
          $error("unexpected result: tdata %0h, tlast %0b", out_tdata, out_tlast);
          errs++;
        end else begin
          want = decoded_q.pop_front();
          check_field("is_end",        64'(want.is_end),        64'(out_tlast));
          check_field("ordinal",       64'(want.ordinal),       64'(out_tdata[15:0]));
          check_field("is_selected",   64'(want.is_selected),   64'(out_tdata[16]));
          check_field("name_low",      want.name_low,           out_tdata[80:17]);
          check_field("name_high",     64'(want.name_high),     64'(out_tdata[112:81]));
          check_field("name_length",   64'(want.name_length),   64'(out_tdata[116:113]));
          check_field("start_cluster", 64'(want.start_cluster), 64'(out_tdata[148:117]));
          check_field("is_directory",  64'(want.is_directory),  64'(out_tdata[149]));
          check_field("size_bytes",    64'(want.size_bytes),    64'(out_tdata[181:150]));
          check_field("pad",           64'(0),                  64'(out_tdata[183:182]));
        end
      end
      if (in_tvalid && in_tready) begin
        if (decode_entry(in_tdata, in_tuser, want)) decoded_q.push_back(want);
      end
    end
    fail_count    <= errs;
    pending_count <= decoded_q.size();
  end

endmodule

// ===== dv/fat_directory_entry_scanner_unit_test.sv =====
// fat_directory_entry_scanner_unit_test: drives directory entries into the scanner with
// random gaps and result stalls; prediction and comparison live in fdes_scan_checker
// depends on fdes_pkg, fdes_scan_checker and the scanner rtl
module fat_directory_entry_scanner_unit_test
  import fdes_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAND_ITEMS = 1680;
  localparam int STEADY_RUN = 48;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_WAIT = 8;

  typedef struct {
    logic [63:0] name;
    logic [23:0] ext;
    logic [7:0]  attr;
    logic [15:0] clus_hi;
    logic [15:0] clus_lo;
    logic [31:0] size;
    logic        new_dir;
    logic [15:0] wanted;
  } dir_entry_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [175:0] in_tdata;
  logic         in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [183:0] out_tdata;
  logic         out_tlast;
  int           fail_count;
  int           pending_count;

  int burst_left = 0;
  bit steady = 0;
  int sent = 0;
  int idle_cycles = 0;

  fat_directory_entry_scanner_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  fdes_scan_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // text literals keep the first character in the top byte; entries want it in byte 0
  function automatic logic [63:0] base_text(input logic [63:0] s);
    logic [63:0] r;
    for (int k = 0; k < 8; k++) r[8*k +: 8] = s[8*(7-k) +: 8];
    return r;
  endfunction

  function automatic logic [23:0] ext_text(input logic [23:0] s);
    return {s[7:0], s[15:8], s[23:16]};
  endfunction

  function automatic logic [7:0] rand_char();
    case ($urandom_range(0, 4))
      0, 1:    return 8'h41 + 8'($urandom_range(0, 25));
      2:       return 8'h61 + 8'($urandom_range(0, 25));
      3:       return 8'h30 + 8'($urandom_range(0, 9));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // space padded name with random content; first byte never ends or deletes
  function automatic logic [63:0] rand_name();
    logic [63:0] r;
    int fill;
    fill = $urandom_range(0, 8);
    for (int k = 0; k < 8; k++) begin
      if (k < fill) r[8*k +: 8] = rand_char();
      else if ($urandom_range(0, 9) == 0) r[8*k +: 8] = 8'($urandom_range(0, 255));
      else r[8*k +: 8] = BYTE_SPACE;
    end
    while (r[7:0] == BYTE_END || r[7:0] == BYTE_DELETED) r[7:0] = rand_char();
    return r;
  endfunction

  function automatic logic [23:0] rand_ext();
    logic [23:0] r;
    int fill;
    fill = $urandom_range(0, 3);
    for (int k = 0; k < 3; k++) begin
      if (k < fill) r[8*k +: 8] = rand_char();
      else if ($urandom_range(0, 9) == 0) r[8*k +: 8] = 8'($urandom_range(0, 255));
      else r[8*k +: 8] = BYTE_SPACE;
    end
    if (fill == 0) r[7:0] = BYTE_SPACE;
    return r;
  endfunction

  function automatic dir_entry_t rand_visible(input logic new_dir, input logic [15:0] wanted);
    dir_entry_t e;
    e.name    = rand_name();
    e.ext     = rand_ext();
    e.attr    = 8'($urandom_range(0, 255)) & ~ATTR_VOLUME;
    e.clus_hi = 16'($urandom);
    e.clus_lo = 16'($urandom);
    e.size    = $urandom;
    e.new_dir = new_dir;
    e.wanted  = wanted;
    return e;
  endfunction

  function automatic dir_entry_t rand_noise(input logic new_dir);
    dir_entry_t e;
    e.name    = {$urandom, $urandom};
    e.ext     = 24'($urandom);
    e.attr    = 8'($urandom);
    e.clus_hi = 16'($urandom);
    e.clus_lo = 16'($urandom);
    e.size    = $urandom;
    e.new_dir = new_dir;
    e.wanted  = 16'($urandom);
    return e;
  endfunction

  function automatic dir_entry_t make_entry(input logic [63:0] name, input logic [23:0] ext,
                                            input logic [7:0] attr, input logic new_dir,
                                            input logic [15:0] wanted);
    dir_entry_t e;
    e = rand_noise(new_dir);
    e.name   = name;
    e.ext    = ext;
    e.attr   = attr;
    e.wanted = wanted;
    return e;
  endfunction

  // sender: bursts of random length separated by random gaps
  task automatic send_entry(input dir_entry_t e);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {e.wanted, e.size, e.clus_lo, e.clus_hi, e.attr, e.ext, e.name};
    in_tuser  <= e.new_dir;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  // receiver: runs of always ready, random ready, mostly ready and long stalls
  initial begin
    int run;
    int mode;
    out_tready = 1'b0;
    run = 0;
    mode = 0;
    forever begin
      @(posedge clk);
      if (run == 0) begin
        mode = $urandom_range(0, 3);
        run = $urandom_range(8, 64);
      end
      run--;
      case (mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= ($urandom_range(0, 1) == 1);
        2:       out_tready <= ($urandom_range(0, 3) != 0);
        default: out_tready <= (run % 12 == 0);
      endcase
    end
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    dir_entry_t e;
    int n;
    int vis;
    int pick;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    rst_n     = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: name shapes, field extremes, skipped kinds, end handling
    e = make_entry(base_text("README  "), ext_text("TXT"), 8'h20, 1'b1, 16'h0000);
    e.clus_hi = '0; e.clus_lo = '0; e.size = '0;
    send_entry(e);
    e = make_entry(base_text("ABCDEFGH"), ext_text("XYZ"), ATTR_DIR, 1'b0, 16'hFFFF);
    e.clus_hi = 16'hFFFF; e.clus_lo = 16'hFFFF; e.size = 32'hFFFF_FFFF;
    send_entry(e);
    send_entry(make_entry(base_text("        "), ext_text("   "), 8'h00, 1'b0, 16'h0002));
    send_entry(make_entry(base_text("        "), ext_text("DAT"), 8'h01, 1'b0, 16'h0001));
    send_entry(make_entry(base_text("A B     "), ext_text("T X"), 8'h02, 1'b0, 16'h0004));
    // nul inside the name, case boundaries and high bytes
    send_entry(make_entry(64'h2020_2020_5B40_0041, 24'hFF_7F61, 8'hF7, 1'b0, 16'h0000));
    send_entry(make_entry(base_text("Zz@[`{ ~"), ext_text("a Z"), 8'hE0, 1'b0, 16'h0006));
    send_entry(make_entry({56'h20_2020_2020_4F4B, BYTE_DELETED}, ext_text("TMP"),
                          8'h20, 1'b0, 16'h0007));
    send_entry(make_entry(base_text("LONGNAME"), ext_text("   "), ATTR_LONGNAME, 1'b0, 16'h0007));
    send_entry(make_entry(base_text("VOLUME  "), ext_text("   "), ATTR_VOLUME, 1'b0, 16'h0007));
    send_entry(make_entry(base_text("VOLALL  "), ext_text("   "), 8'hFF, 1'b0, 16'h0007));
    send_entry(make_entry(base_text("VOLDIR  "), ext_text("   "), 8'h0E, 1'b0, 16'h0007));
    send_entry(make_entry(base_text("SEVEN   "), ext_text("BIN"), 8'h07, 1'b0, 16'h0007));
    send_entry(make_entry(64'hFFFF_FFFF_FFFF_FF00, 24'hFFFFFF, 8'hFF, 1'b0, 16'h0008));
    send_entry(make_entry(base_text("LATE    "), ext_text("TXT"), 8'h20, 1'b0, 16'h0008));
    send_entry(make_entry(64'h0, 24'h0, 8'h00, 1'b0, 16'h0000));
    send_entry(make_entry(64'h0, 24'h0, 8'h00, 1'b1, 16'h0000));
    send_entry(make_entry(base_text("NEXT    "), ext_text("TXT"), 8'h20, 1'b1, 16'h0000));
    send_entry(make_entry({56'h20_2020_2020_4F4B, BYTE_DELETED}, ext_text("   "),
                          8'h00, 1'b1, 16'h0000));
    send_entry(make_entry(base_text("FIRST   "), ext_text("C  "), 8'h20, 1'b0, 16'h0000));
    send_entry(make_entry(base_text("SECOND  "), ext_text("H  "), 8'h20, 1'b0, 16'h0001));
    send_entry(make_entry(base_text("RESTART "), ext_text("   "), ATTR_DIR, 1'b1, 16'h0000));

    // back-to-back run: one long directory without idling on the sender
    steady = 1;
    for (int i = 0; i < STEADY_RUN; i++)
      send_entry(rand_visible(i == 0, (i >= STEADY_RUN - 4) ? 16'(i) : 16'($urandom)));
    send_entry(make_entry({56'($urandom), BYTE_END}, 24'($urandom), 8'($urandom),
                          1'b0, 16'($urandom)));
    steady = 0;

    // random directories: mostly well formed, some noise and unterminated runs
    n = sent + RAND_ITEMS;
    while (sent < n) begin
      if ($urandom_range(0, 6) == 0) begin
        send_entry(rand_noise($urandom_range(0, 7) == 0));
      end else begin
        vis = 0;
        for (int j = 0; j <= $urandom_range(0, 30); j++) begin
          e = rand_visible(j == 0, ($urandom_range(0, 1) == 1) ?
                                   16'($urandom_range(0, vis + 2)) : 16'($urandom));
          pick = $urandom_range(0, 99);
          if (pick < 72) begin
            vis++;
          end else if (pick < 82) begin
            e.name[7:0] = BYTE_DELETED;
          end else if (pick < 90) begin
            e.attr = ATTR_LONGNAME;
          end else if (pick < 96) begin
            e.attr = 8'($urandom) | ATTR_VOLUME;
          end else begin
            e = rand_noise(j == 0);
          end
          send_entry(e);
        end
        if ($urandom_range(0, 4) != 0) begin
          e = rand_noise(1'b0);
          e.name[7:0] = BYTE_END;
          send_entry(e);
          repeat ($urandom_range(0, 3)) send_entry(rand_noise(1'b0));
        end
      end
    end

    // drain: let the last prediction reach the pending count, then allow for latency
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
